/* hw/rtl/slt_pkg.sv */
// shared types and codes for the sorted list table
`timescale 1ns / 1ps
`default_nettype none
package slt_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 16;

    localparam int REQ_W   = 2;
    localparam int KEY_W   = 16;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

    // per-cycle control broadcast along the cell row
    typedef struct packed {
        logic capture;    // latch compare flags against the key
        logic do_insert;  // open a gap at the insert point
        logic do_remove;  // close the gap at the matching entry
    } slt_ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/slt_cell.sv */
// one entry of the sorted row: compare flags and shift-in from either neighbour
`timescale 1ns / 1ps
`default_nettype none
module slt_cell
    import slt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire slt_ctrl_t             ctrl,
    input  wire logic                  valid,
    input  wire logic [VALUE_BITS-1:0] key,
    input  wire logic [VALUE_BITS-1:0] left_value,
    input  wire logic [VALUE_BITS-1:0] right_value,
    input  wire logic                  left_lt,
    output logic [VALUE_BITS-1:0]      value_o,
    output logic                       lt_o,
    output logic                       hit_o
);

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic                  lt_reg;
    logic                  eq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end else if (ctrl.capture) begin
            lt_reg <= valid && (value_reg < key);
            eq_reg <= valid && (value_reg == key);
        end
    end

    // lt flags form a thermometer, so the first cell not below the key sits
    // where the left neighbour is still below it
    always_comb begin
        value_next = value_reg;
        if (ctrl.do_insert && !lt_reg) begin
            value_next = left_lt ? key : left_value;
        end else if (ctrl.do_remove && !lt_reg) begin
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value_o = value_reg;
    assign lt_o    = lt_reg;
    assign hit_o   = eq_reg && !lt_reg && left_lt;

endmodule
`default_nettype wire

/* hw/rtl/sorted_list_table.sv */
// sorted list table: top level with request sequencer and row of compare cells
//
//   channel   dir   fields (lsb first)                    transfer when
//   s_axis    in    req_type[1:0], value[17:2]            s_tvalid && s_tready
//   m_axis    out   status[1:0], found[2], count[7:3]     m_tvalid && m_tready
//
// a request passes through the accept, a compare state in which every cell
// registers its compare flags against the key, and an update state in which found
// is reduced across the row and each cell shifts left, right or holds
// the update cycle waits while the previous result is still held on m_axis
// reset clears the entry count, the sequencer and the output valid; entry
// storage is not cleared, only cells below the count are ever looked at
`timescale 1ns / 1ps
`default_nettype none
module sorted_list_table
    import slt_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // req_type[1:0], value[17:2], zero fill
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // status[1:0], found[2], count[7:3]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [REQ_W-1:0]      req_reg;
    logic [VALUE_BITS-1:0] key_reg;
    logic [VALUE_BITS-1:0] key_in;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    logic                  m_tvalid_reg;
    logic [STAT_W-1:0]     status_reg;
    logic [STAT_W-1:0]     status_next;
    logic                  found_reg;
    logic [COUNT_W-1:0]    count_out_reg;
    logic [COUNT_W-1:0]    count_field;

    logic                  s_fire;
    logic                  exec_fire;
    logic                  full;
    logic                  found;
    slt_ctrl_t             ctrl;

    logic [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]   cell_lt;
    logic [CAPACITY-1:0]   cell_hit;
    logic [CAPACITY-1:0]   cell_valid;

    // key keeps the low VALUE_BITS bits of the field, zero-extended if wider than KEY_W; count is fitted to COUNT_W
    generate
        if (VALUE_BITS <= KEY_W) begin : g_key_narrow
            assign key_in = s_tdata[REQ_W +: VALUE_BITS];
        end else begin : g_key_wide
            assign key_in = {{(VALUE_BITS - KEY_W){1'b0}}, s_tdata[REQ_W +: KEY_W]};
        end
        if (CNT_W >= COUNT_W) begin : g_cnt_trunc
            assign count_field = count_next[COUNT_W-1:0];
        end else begin : g_cnt_ext
            assign count_field = {{(COUNT_W - CNT_W){1'b0}}, count_next};
        end
    endgenerate

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign exec_fire = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign found     = |cell_hit;

    always_comb begin
        ctrl.capture   = (state_reg == S_CMP);
        ctrl.do_insert = exec_fire && (req_reg == REQ_INSERT) && !full;
        ctrl.do_remove = exec_fire && (req_reg == REQ_REMOVE) && found;
    end

    // entry i is live while i is below the count
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_valid[i] = (CNT_W'(i) < count_reg);
        end
    end

    // the row: each cell sees its neighbours' values and the left lt flag
    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            logic [VALUE_BITS-1:0] left_v;
            logic [VALUE_BITS-1:0] right_v;
            logic                  left_l;
            if (i == 0) begin : g_first
                assign left_v = key_reg;
                assign left_l = 1'b1;
            end else begin : g_mid
                assign left_v = cell_value[i-1];
                assign left_l = cell_lt[i-1];
            end
            if (i == CAPACITY - 1) begin : g_last
                assign right_v = cell_value[i];
            end else begin : g_inner
                assign right_v = cell_value[i+1];
            end
            slt_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .valid       (cell_valid[i]),
                .key         (key_reg),
                .left_value  (left_v),
                .right_value (right_v),
                .left_lt     (left_l),
                .value_o     (cell_value[i]),
                .lt_o        (cell_lt[i]),
                .hit_o       (cell_hit[i])
            );
        end
    endgenerate

    // result and new count for the request under way
    always_comb begin
        count_next  = count_reg;
        status_next = STAT_DONE;
        case (req_reg)
            REQ_INSERT: begin
                if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_SEARCH: begin
                if (!found) begin
                    status_next = STAT_NOT_FOUND;
                end
            end
            REQ_REMOVE: begin
                if (found) begin
                    count_next = count_reg - 1'b1;
                end else begin
                    status_next = STAT_NOT_FOUND;
                end
            end
            default: begin
                status_next = STAT_DONE;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (exec_fire) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (exec_fire) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg <= s_tdata[REQ_W-1:0];
            key_reg <= key_in;
        end
        if (exec_fire) begin
            status_reg    <= status_next;
            found_reg     <= found && (req_reg == REQ_SEARCH || req_reg == REQ_REMOVE);
            count_out_reg <= count_field;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {count_out_reg, found_reg, status_reg};

    // checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EXEC |-> $onehot0(cell_hit))
        else $error("more than one cell claims the lower bound");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire |=> m_tvalid_reg)
        else $error("completed request left no result");

    a_remove_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.do_remove |=> count_reg == $past(count_reg) - 1'b1)
        else $error("remove did not drop the count by one");

    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && req_reg == REQ_INSERT && full |=> count_reg == $past(count_reg))
        else $error("refused insert changed the count");

endmodule
`default_nettype wire

/* sim/tb.sv */
// self-checking testbench for the sorted list table: directed corner cases then random traffic
`timescale 1ns / 1ps
module tb;
    import slt_pkg::*;

    localparam int                TABLE_DEPTH = CAPACITY_DEF;
    localparam logic [REQ_W-1:0]  REQ_UNUSED  = 2'd3;
    localparam int                IDLE_PCT    = 6;
    localparam int                STALL_LIMIT = 2000;
    localparam int                RANDOM_REQS = 750;

    // one result transfer as the table reports it
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               found;
        logic [COUNT_W-1:0] count;
    } table_reply_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;

    // mirror of the table contents, kept in ascending order
    logic [KEY_W-1:0]  mirror_keys [TABLE_DEPTH];
    int unsigned       mirror_fill = 0;
    table_reply_t      pending_replies [$];

    bit                calm = 1'b0;      // no idling on either side while set
    int unsigned       errors = 0;
    int unsigned       replies_checked = 0;
    int unsigned       idle_cycles = 0;
    int unsigned       kind_seen [4] = '{0, 0, 0, 0};
    int unsigned       full_refusals = 0;
    int unsigned       misses = 0;
    int unsigned       peak_fill = 0;

    sorted_list_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // applies one request to the mirror and gives the reply it must produce
    function automatic table_reply_t apply_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key);
        table_reply_t reply;
        int unsigned  pos;
        int unsigned  i;
        reply.status = STAT_DONE;
        reply.found  = 1'b0;
        pos = 0;
        while (pos < mirror_fill && mirror_keys[pos] < key)
            pos++;
        case (req)
            REQ_INSERT: begin
                if (mirror_fill >= TABLE_DEPTH) begin
                    reply.status = STAT_FULL;
                    full_refusals++;
                end else begin
                    for (i = mirror_fill; i > pos; i--)
                        mirror_keys[i] = mirror_keys[i-1];
                    mirror_keys[pos] = key;
                    mirror_fill++;
                end
            end
            REQ_SEARCH, REQ_REMOVE: begin
                if (pos < mirror_fill && mirror_keys[pos] == key) begin
                    reply.found = 1'b1;
                    if (req == REQ_REMOVE) begin
                        for (i = pos; i + 1 < mirror_fill; i++)
                            mirror_keys[i] = mirror_keys[i+1];
                        mirror_fill--;
                    end
                end else begin
                    reply.status = STAT_NOT_FOUND;
                    misses++;
                end
            end
            default: ;  // unused code leaves the table alone
        endcase
        reply.count = COUNT_W'(mirror_fill);
        if (mirror_fill > peak_fill)
            peak_fill = mirror_fill;
        return reply;
    endfunction

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        $display("%0t: mismatch in %s: expected %0d, got %0d", $time, what, want, got);
        errors++;
    endtask

    // one request transfer, with a random gap in front of it
    task automatic send_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, key, req};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        kind_seen[req]++;
        pending_replies.push_back(apply_request(req, key));
    endtask

    // stop sending and let every outstanding reply come back
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic test_empty_table();
        send_request(REQ_SEARCH, 16'd0);        // nothing stored yet
        send_request(REQ_REMOVE, 16'd5);        // remove from empty
        send_request(REQ_UNUSED, 16'hffff);
        send_request(REQ_INSERT, 16'hffff);
        send_request(REQ_SEARCH, 16'hffff);
        send_request(REQ_REMOVE, 16'hffff);     // only entry goes, table empties
        send_request(REQ_INSERT, 16'd0);
    endtask

    task automatic test_full_table();
        logic [KEY_W-1:0] keys [15] = '{16'h8000, 16'h0001, 16'hffff, 16'h0000, 16'h7fff,
                                         16'h8000, 16'haaaa, 16'h5555, 16'h0000, 16'hfffe,
                                         16'h1234, 16'hffff, 16'h0002, 16'h8001, 16'h4000};
        foreach (keys[k])
            send_request(REQ_INSERT, keys[k]);
        send_request(REQ_INSERT, 16'h3333);     // refused, table full
        send_request(REQ_SEARCH, 16'h0000);     // match sits in the first slot
        send_request(REQ_UNUSED, 16'h0000);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(99);
        if (mirror_fill > 0 && r < 45)
            return mirror_keys[$urandom_range(mirror_fill - 1)];
        if (r < 72)
            return KEY_W'($urandom_range(15));    // narrow range gives duplicates
        return KEY_W'($urandom_range(16'hffff));
    endfunction

    task automatic test_random_traffic();
        int unsigned      n;
        int unsigned      r;
        int unsigned      insert_pct;
        int unsigned      remove_pct;
        logic [REQ_W-1:0] req;
        for (n = 0; n < RANDOM_REQS; n++) begin
            calm = (n >= 250 && n < 400);
            if (n == 500)
                wait_drained();
            // alternate fill-heavy and drain-heavy phases so both ends get visited
            insert_pct = ((n / 60) % 2) ? 30 : 55;
            remove_pct = ((n / 60) % 2) ? 45 : 20;
            r = $urandom_range(99);
            if (r < 3)
                req = REQ_UNUSED;
            else if (r < 3 + insert_pct)
                req = REQ_INSERT;
            else if (r < 3 + insert_pct + remove_pct)
                req = REQ_REMOVE;
            else
                req = REQ_SEARCH;
            send_request(req, pick_key());
        end
        calm = 1'b0;
    endtask

    // receiver stalls, none during the calm stretch
    always @(negedge aclk)
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // compare every result transfer with the oldest predicted reply
    always @(posedge aclk) begin
        table_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("requests outstanding", 1, 0);
            end else begin
                want = pending_replies.pop_front();
                replies_checked++;
                if (m_tdata[1:0] !== want.status)
                    report_mismatch("status", want.status, m_tdata[1:0]);
                if (m_tdata[2] !== want.found)
                    report_mismatch("found", want.found, m_tdata[2]);
                if (m_tdata[7:3] !== want.count)
                    report_mismatch("count", want.count, m_tdata[7:3]);
            end
        end
    end

    // ends the run if neither channel moves for too long
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("[sorted_list_table] ERROR");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_full_table();
        wait_drained();
        test_random_traffic();
        wait_drained();

        $display("covered %0d inserts, %0d searches, %0d removes, %0d unused codes",
                 kind_seen[REQ_INSERT], kind_seen[REQ_SEARCH], kind_seen[REQ_REMOVE],
                 kind_seen[REQ_UNUSED]);
        $display("%0d results checked, %0d full refusals, %0d misses, peak fill %0d",
                 replies_checked, full_refusals, misses, peak_fill);
        if (errors == 0)
            $display("[sorted_list_table] OK");
        else
            $display("[sorted_list_table] ERROR");
        $finish;
    end

endmodule
